/* src/bpc_pkg.sv */
// Shared types, constants and register indexes for the brush pixel compositor.
package bpc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned ColorW   = 32;

  localparam logic [ColorW-1:0] MaskRb   = 32'h00FF_00FF;
  localparam logic [ColorW-1:0] MaskAg   = 32'hFF00_FF00;
  localparam logic [ColorW-1:0] OneAlpha = 32'h0100_0000;
  localparam logic [ChanW:0]    WeightOne = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BRUSH_RED    = 2'd0,
    CFG_BRUSH_GREEN  = 2'd1,
    CFG_BRUSH_BLUE   = 2'd2,
    CFG_ERASE_ENABLE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             erase;
  } brush_cfg_t;

endpackage

/* src/bpc_cfg.sv */
// Configuration register file: brush color and erase mode.
module bpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data,
  output bpc_pkg::brush_cfg_t           brush_cfg
);
  import bpc_pkg::*;

  brush_cfg_t cfg_r;
  brush_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign brush_cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BRUSH_RED:    cfg_nxt.red   = cfg_data;
        CFG_BRUSH_GREEN:  cfg_nxt.green = cfg_data;
        CFG_BRUSH_BLUE:   cfg_nxt.blue  = cfg_data;
        CFG_ERASE_ENABLE: cfg_nxt.erase = cfg_data[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/bpc_blend.sv */
// Combinational pixel blend: packed brush color over old color, or zero in erase mode.
module bpc_blend (
  input  bpc_pkg::brush_cfg_t             brush_cfg,
  input  logic [bpc_pkg::ChanW-1:0]       coverage,
  input  logic [bpc_pkg::ColorW-1:0]      old_color,
  output logic                            write_enable,
  output logic [bpc_pkg::ColorW-1:0]      new_color
);
  import bpc_pkg::*;

  logic [ColorW-1:0] src;
  logic [ColorW-1:0] a_w;
  logic [ColorW-1:0] na_w;
  logic [ColorW-1:0] rb_sum;
  logic [ColorW-1:0] ag_sum;
  logic [ColorW-1:0] rb;
  logic [ColorW-1:0] blended;

  assign src  = {coverage, brush_cfg.blue, brush_cfg.green, brush_cfg.red};
  assign a_w  = {{(ColorW-ChanW){1'b0}}, coverage};
  assign na_w = {{(ColorW-ChanW-1){1'b0}}, WeightOne - {1'b0, coverage}};

  // Both sums wrap at 32 bits.
  assign rb_sum = na_w * (old_color & MaskRb) + a_w * (src & MaskRb);
  assign ag_sum = na_w * ((old_color & MaskAg) >> 8)
                + a_w * (OneAlpha | {{(ColorW-ChanW){1'b0}}, brush_cfg.green});
  assign rb      = rb_sum >> 8;
  assign blended = (rb & MaskRb) | (ag_sum & MaskAg);

  always_comb begin
    write_enable = (coverage != '0);
    if (!write_enable || brush_cfg.erase) begin
      new_color = '0;
    end else if (old_color[ColorW-1 -: ChanW] == '0) begin
      // transparent destination: brush color unblended
      new_color = src;
    end else begin
      new_color = blended;
    end
  end

endmodule

/* src/brush_pixel_composite.sv */
// Brush pixel compositor top level: input register, blend, result register.
// Data path: a request is captured in the input reg, blended, then registered in the result reg.
// Throughput: one pixel per cycle while out_stall is low; the blend is one combinational pass with two
//   packed multiply-add pairs between the input and result registers.
// Backpressure: out_stall holds the result reg; in_stall rises only when both regs
//   are full and the result is stalled.
// Reset (rst_n, sync, active low): pipeline empty, all brush registers zero.
module brush_pixel_composite (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpc_pkg::ChanW-1:0]     in_coverage,
  input  logic [bpc_pkg::ColorW-1:0]    in_old_color,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_write_enable,
  output logic [bpc_pkg::ColorW-1:0]    out_new_color,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgDataW-1:0]  cfg_data
);
  import bpc_pkg::*;

  brush_cfg_t        brush_cfg;

  // stage 1: input register
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  logic [ChanW-1:0]  s1_cov_r;
  logic [ColorW-1:0] s1_old_r;

  // stage 2: result register
  logic              s2_vld_r;
  logic              s2_vld_nxt;
  logic              s2_we_r;
  logic [ColorW-1:0] s2_color_r;

  logic              blend_we;
  logic [ColorW-1:0] blend_color;
  logic              s1_load;
  logic              s2_load;
  logic              s2_free;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .brush_cfg (brush_cfg)
  );

  bpc_blend u_blend (
    .brush_cfg    (brush_cfg),
    .coverage     (s1_cov_r),
    .old_color    (s1_old_r),
    .write_enable (blend_we),
    .new_color    (blend_color)
  );

  // Result reg frees up when empty or being taken this cycle.
  assign s2_free  = !s2_vld_r || !out_stall;
  assign s2_load  = s1_vld_r && s2_free;
  // Input reg can take a new request when empty or moving forward.
  assign in_stall = s1_vld_r && !s2_free;
  assign s1_load  = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (s1_load) begin
      s1_vld_nxt = 1'b1;
    end else if (s2_load) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_vld_nxt = s2_vld_r;
    if (s2_load) begin
      s2_vld_nxt = 1'b1;
    end else if (s2_vld_r && !out_stall) begin
      s2_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cov_r <= in_coverage;
      s1_old_r <= in_old_color;
    end
    if (s2_load) begin
      s2_we_r    <= blend_we;
      s2_color_r <= blend_color;
    end
  end

  assign out_valid        = s2_vld_r;
  assign out_write_enable = s2_we_r;
  assign out_new_color    = s2_color_r;

endmodule
